// ----- rtl/core/cvwm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cvwm_pkg;

  // cells per frame that are checked; later positions are inactive
  localparam int unsigned CELLS = 6;

  localparam int unsigned VOLT_W  = 16;
  localparam int unsigned TOTAL_W = 20;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned SKIP_W  = 4;
  localparam int unsigned CFG_W   = 20;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [VOLT_W-1:0]  CELL_LOW_RST  = 16'd30000;
  localparam logic [VOLT_W-1:0]  CELL_HIGH_RST = 16'd42000;
  localparam logic [TOTAL_W-1:0] PACK_LOW_RST  = 20'd180000;
  localparam logic [SKIP_W-1:0]  SKIP_RST      = 4'd0;

  typedef enum logic [1:0] {
    REG_CELL_LOW  = 2'd0,
    REG_CELL_HIGH = 2'd1,
    REG_PACK_LOW  = 2'd2,
    REG_SKIPPED   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_UNDER    = 2'd1,
    STATUS_OVER     = 2'd2,
    STATUS_READ_ERR = 2'd3
  } frame_status_t;

  // result payload, first field in the highest bits
  typedef struct packed {
    logic [POS_W-1:0]   lowest_cell;
    logic [TOTAL_W-1:0] pack_total;
    frame_status_t      frame_status;
    logic               over_fault;
    logic               under_fault;
    logic [POS_W-1:0]   cell_position;
  } result_data_t;

  typedef struct packed {
    logic         flag_update;
    logic         frame_done;
    result_data_t data;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/cell_voltage_window_monitor.sv -----
`timescale 1ns / 1ps
`default_nettype none

// cell voltage window monitor
//
// in_*  : one cell reading per transfer. in_tdata holds the voltage in 100 uV
//         units, in_tuser flags a failed chip read, in_tlast marks the last
//         cell of a measurement frame.
// out_* : one result per input transfer, in order. out_tdata carries the cell
//         position and its fault flags, and on the last cell (out_tlast) the
//         frame status, pack total and lowest cell index. out_tuser says the
//         fault flags apply to this cell.
// cfg_* : register writes (limits, skipped cells), taken at once; write only
//         while no result is outstanding.
//
// each result is registered in the output register, or in the skid register
// while the output stalls. throughput is one reading per cycle while
// in_tready is high, set by the single compare/add/min update of frame state.
// when the receiver stalls, one more result is parked in a skid register and
// in_tready then drops until the parked result moves to the output.
// reset (rst_n low, synchronous) empties both registers, clears the frame
// state and loads the register defaults.

module cell_voltage_window_monitor
  import cvwm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [VOLT_W-1:0]   in_tdata,   // cell_voltage[15:0]
  input  wire logic                in_tuser,   // read_failed[0]
  input  wire logic                in_tlast,

  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // cell_position[3:0], under_fault[4], over_fault[5], frame_status[7:6],
  // pack_total[27:8], lowest_cell[31:28]
  output logic [31:0]              out_tdata,
  output logic                     out_tuser,  // flag_update[0]
  output logic                     out_tlast,

  input  wire logic                cfg_wr_en,
  input  wire logic [1:0]          cfg_addr,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  localparam logic [POS_W:0] CELLS_LIM = (POS_W+1)'(CELLS);

  // configuration
  logic [VOLT_W-1:0]  cell_low_r, cell_high_r;
  logic [TOTAL_W-1:0] pack_low_r;
  logic [SKIP_W-1:0]  skipped_r;

  // frame state
  logic [POS_W-1:0]   pos_cnt_r,   pos_cnt_nxt;
  logic [TOTAL_W-1:0] total_r,     total_nxt;
  logic [VOLT_W-1:0]  low_val_r,   low_val_nxt;
  logic [POS_W-1:0]   low_idx_r,   low_idx_nxt;
  logic               low_vld_r,   low_vld_nxt;
  frame_status_t      status_r,    status_nxt;
  logic               fail_r,      fail_nxt;

  // output register and skid register
  logic    out_vld_r, out_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t out_r, out_nxt;
  result_t skid_r;

  logic    in_xfer, out_xfer, out_load, skid_load;

  logic [VOLT_W-1:0]  volt;
  logic               active, is_under, is_over;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_sat;
  frame_status_t      final_status;
  result_t            res;

  assign in_tready = !skid_vld_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_vld_r && out_tready;

  // per-cell evaluation against the current frame state
  always_comb begin
    volt     = in_tdata;
    active   = (pos_cnt_r >= skipped_r) && ({1'b0, pos_cnt_r} < CELLS_LIM);
    fail_nxt = fail_r | in_tuser;
    is_under = (volt <= cell_low_r);
    is_over  = !is_under && (volt >= cell_high_r);

    sum       = {1'b0, total_r} + {{(TOTAL_W+1-VOLT_W){1'b0}}, volt};
    total_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

    status_nxt  = status_r;
    total_nxt   = total_r;
    low_val_nxt = low_val_r;
    low_idx_nxt = low_idx_r;
    low_vld_nxt = low_vld_r;

    if (active) begin
      if (is_under) begin
        status_nxt = STATUS_UNDER;
      end else if (is_over) begin
        status_nxt = STATUS_OVER;
      end
      total_nxt = total_sat;
      // first active cell always takes the minimum, then strictly lower only
      if (!low_vld_r || volt < low_val_r) begin
        low_val_nxt = volt;
        low_idx_nxt = pos_cnt_r;
        low_vld_nxt = 1'b1;
      end
    end

    final_status = status_nxt;
    if (total_nxt < pack_low_r) begin
      final_status = STATUS_UNDER;
    end
    if (fail_nxt) begin
      final_status = STATUS_READ_ERR;
    end

    res                    = '0;
    res.data.cell_position = pos_cnt_r;
    res.flag_update        = active && !fail_nxt;
    res.data.under_fault   = res.flag_update && is_under;
    res.data.over_fault    = res.flag_update && is_over;
    res.frame_done         = in_tlast;
    if (in_tlast) begin
      res.data.frame_status = final_status;
      res.data.pack_total   = total_nxt;
      res.data.lowest_cell  = low_idx_nxt;
    end

    if (in_tlast) begin
      pos_cnt_nxt = '0;
    end else if (pos_cnt_r != {POS_W{1'b1}}) begin
      pos_cnt_nxt = pos_cnt_r + POS_W'(1);
    end else begin
      pos_cnt_nxt = pos_cnt_r;
    end
  end

  // output / skid steering
  always_comb begin
    out_load     = 1'b0;
    skid_load    = 1'b0;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = res;
    if (in_xfer) begin
      // skid is empty whenever a transfer is taken
      if (!out_vld_r || out_tready) begin
        out_load    = 1'b1;
        out_vld_nxt = 1'b1;
      end else begin
        skid_load    = 1'b1;
        skid_vld_nxt = 1'b1;
      end
    end else if (out_xfer) begin
      if (skid_vld_r) begin
        out_load     = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      skid_vld_r  <= 1'b0;
      pos_cnt_r   <= '0;
      total_r     <= '0;
      low_val_r   <= {VOLT_W{1'b1}};
      low_idx_r   <= '0;
      low_vld_r   <= 1'b0;
      status_r    <= STATUS_OK;
      fail_r      <= 1'b0;
      cell_low_r  <= CELL_LOW_RST;
      cell_high_r <= CELL_HIGH_RST;
      pack_low_r  <= PACK_LOW_RST;
      skipped_r   <= SKIP_RST;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;

      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_CELL_LOW:  cell_low_r  <= cfg_wdata[VOLT_W-1:0];
          REG_CELL_HIGH: cell_high_r <= cfg_wdata[VOLT_W-1:0];
          REG_PACK_LOW:  pack_low_r  <= cfg_wdata[TOTAL_W-1:0];
          REG_SKIPPED:   skipped_r   <= cfg_wdata[SKIP_W-1:0];
          default: ;
        endcase
      end

      if (in_xfer) begin
        pos_cnt_r <= pos_cnt_nxt;
        if (in_tlast) begin
          // frame closed, start the next one clean
          total_r   <= '0;
          low_val_r <= {VOLT_W{1'b1}};
          low_idx_r <= '0;
          low_vld_r <= 1'b0;
          status_r  <= STATUS_OK;
          fail_r    <= 1'b0;
        end else begin
          total_r   <= total_nxt;
          low_val_r <= low_val_nxt;
          low_idx_r <= low_idx_nxt;
          low_vld_r <= low_vld_nxt;
          status_r  <= status_nxt;
          fail_r    <= fail_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
    if (skid_load) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.flag_update;
  assign out_tlast  = out_r.frame_done;

endmodule

`default_nettype wire

// ----- rtl/core/cvwm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cvwm_checker
  import cvwm_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [31:0]        out_tdata,
  input wire logic               out_tuser,
  input wire logic               out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // fault flags only travel with a flag update
  a_flags_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[5:4] == 2'b00)
    else $error("fault flag without flag update");

  // a cell is never both under and over
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[4] && out_tdata[5]))
    else $error("under and over fault together");

  // frame fields are zero away from the frame end
  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[31:6] == '0)
    else $error("frame fields set on a mid-frame result");

  // reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind cell_voltage_window_monitor cvwm_checker u_cvwm_checker (.*);

`default_nettype wire

// ----- verif/cell_voltage_window_monitor_tb.sv -----
`timescale 1ns / 1ps

module cell_voltage_window_monitor_tb;
  import cvwm_pkg::*;

  localparam int HOLD_CYCLES = 50;   // long output stall, fills output and skid registers
  localparam int MAX_REPORTS = 100;  // keep the log short on a badly broken block

  logic clk = 1'b0;
  logic rst_n;

  logic              in_tvalid;
  logic              in_tready;
  logic [VOLT_W-1:0] in_tdata;   // cell_voltage[15:0]
  logic              in_tuser;   // read_failed[0]
  logic              in_tlast;

  logic              out_tvalid;
  logic              out_tready;
  // cell_position[3:0], under_fault[4], over_fault[5], frame_status[7:6],
  // pack_total[27:8], lowest_cell[31:28]
  logic [31:0]       out_tdata;
  logic              out_tuser;  // flag_update[0]
  logic              out_tlast;

  logic              cfg_wr_en;
  cfg_reg_t          cfg_addr;
  logic [CFG_W-1:0]  cfg_wdata;

  cell_voltage_window_monitor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predicted monitor state: limits and the open frame
  // ---------------------------------------------------------------------------
  logic [VOLT_W-1:0]  lim_low  = CELL_LOW_RST;
  logic [VOLT_W-1:0]  lim_high = CELL_HIGH_RST;
  logic [TOTAL_W-1:0] pack_min = PACK_LOW_RST;
  logic [SKIP_W-1:0]  skip_cnt = SKIP_RST;

  logic [POS_W-1:0]   cell_pos_cnt = '0;
  logic [TOTAL_W-1:0] volt_sum     = '0;
  logic [VOLT_W-1:0]  min_volt     = '1;
  logic [POS_W-1:0]   min_idx      = '0;
  frame_status_t      status_acc   = STATUS_OK;
  logic               fail_latch   = 1'b0;
  logic               min_valid    = 1'b0;

  // results still owed by the block, oldest first
  result_t expected_results[$];

  int error_count  = 0;
  int results_seen = 0;

  // idling control shared by the sender and the receiver
  bit quiet     = 1'b0;
  bit long_hold = 1'b0;

  // one row of the directed table; known rows carry a hand-derived result
  typedef struct {
    logic [VOLT_W-1:0] volt;
    logic              failed;
    logic              last;
    bit                has_known;
    result_t           known;
  } reading_row_t;

  reading_row_t directed_rows[$];

  function automatic result_t cell_result(input logic [POS_W-1:0] pos, input logic upd,
                                          input logic under, input logic over,
                                          input logic done, input frame_status_t st,
                                          input logic [TOTAL_W-1:0] total,
                                          input logic [POS_W-1:0] lowest);
    result_t r;
    r.flag_update        = upd;
    r.frame_done         = done;
    r.data.cell_position = pos;
    r.data.under_fault   = under;
    r.data.over_fault    = over;
    r.data.frame_status  = st;
    r.data.pack_total    = total;
    r.data.lowest_cell   = lowest;
    return r;
  endfunction

  function automatic void add_row(input logic [VOLT_W-1:0] volt, input logic failed,
                                  input logic last, input bit has_known,
                                  input result_t known);
    reading_row_t row;
    row.volt      = volt;
    row.failed    = failed;
    row.last      = last;
    row.has_known = has_known;
    row.known     = known;
    directed_rows.push_back(row);
  endfunction

  // classify one reading, fold it into the frame and build its result
  function automatic result_t predict_cell(input logic [VOLT_W-1:0] volt, input logic failed,
                                           input logic last);
    result_t           r;
    logic [POS_W-1:0]  pos;
    logic              active;
    logic              under;
    logic              over;
    logic              upd;
    logic [TOTAL_W:0]  wide_sum;
    frame_status_t     st;
    r      = '0;
    pos    = cell_pos_cnt;
    active = (pos >= skip_cnt) && (pos < CELLS);
    under  = 1'b0;
    over   = 1'b0;
    upd    = 1'b0;
    // a failed read poisons the rest of the frame
    fail_latch = fail_latch | failed;
    if (active) begin
      if (volt <= lim_low) begin
        under      = 1'b1;
        status_acc = STATUS_UNDER;
      end else if (volt >= lim_high) begin
        over       = 1'b1;
        status_acc = STATUS_OVER;
      end
      upd      = !fail_latch;
      wide_sum = {1'b0, volt_sum} + volt;
      volt_sum = (wide_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : wide_sum[TOTAL_W-1:0];
      // strict compare keeps the first cell on ties
      if (!min_valid || volt < min_volt) begin
        min_volt  = volt;
        min_idx   = pos;
        min_valid = 1'b1;
      end
    end
    r.data.cell_position = pos;
    r.flag_update        = upd;
    r.data.under_fault   = upd & under;
    r.data.over_fault    = upd & over;
    if (last) begin
      st = status_acc;
      if (volt_sum < pack_min) st = STATUS_UNDER;
      if (fail_latch) st = STATUS_READ_ERR;
      r.frame_done        = 1'b1;
      r.data.frame_status = st;
      r.data.pack_total   = volt_sum;
      r.data.lowest_cell  = min_idx;
      cell_pos_cnt = '0;
      volt_sum     = '0;
      min_volt     = '1;
      min_idx      = '0;
      status_acc   = STATUS_OK;
      fail_latch   = 1'b0;
      min_valid    = 1'b0;
    end else if (cell_pos_cnt != 4'd15) begin
      cell_pos_cnt = cell_pos_cnt + 1'b1;
    end
    return r;
  endfunction

  // readings cluster around the limits so both compares flip often
  function automatic logic [VOLT_W-1:0] pick_voltage();
    int v;
    case ($urandom_range(0, 6))
      0:       v = int'(lim_low) + int'($urandom_range(0, 4)) - 2;
      1:       v = int'(lim_high) + int'($urandom_range(0, 4)) - 2;
      2:       v = $urandom_range(lim_low, lim_high);
      3:       v = $urandom_range(0, 65535);
      4:       v = $urandom_range(0, 1) ? 0 : 65535;
      default: v = $urandom_range(33000, 40000);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[VOLT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // reporting and compare
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_result(input result_t got, input result_t want);
    string tag;
    tag = $sformatf("result %0d", results_seen);
    if (got.data.cell_position !== want.data.cell_position)
      report_mismatch($sformatf("%s cell_position got %0d want %0d", tag,
                                got.data.cell_position, want.data.cell_position));
    if (got.flag_update !== want.flag_update)
      report_mismatch($sformatf("%s flag_update got %0b want %0b", tag,
                                got.flag_update, want.flag_update));
    if (got.data.under_fault !== want.data.under_fault)
      report_mismatch($sformatf("%s under_fault got %0b want %0b", tag,
                                got.data.under_fault, want.data.under_fault));
    if (got.data.over_fault !== want.data.over_fault)
      report_mismatch($sformatf("%s over_fault got %0b want %0b", tag,
                                got.data.over_fault, want.data.over_fault));
    if (got.frame_done !== want.frame_done)
      report_mismatch($sformatf("%s frame_done got %0b want %0b", tag,
                                got.frame_done, want.frame_done));
    if (got.data.frame_status !== want.data.frame_status)
      report_mismatch($sformatf("%s frame_status got %0d want %0d", tag,
                                got.data.frame_status, want.data.frame_status));
    if (got.data.pack_total !== want.data.pack_total)
      report_mismatch($sformatf("%s pack_total got %0d want %0d", tag,
                                got.data.pack_total, want.data.pack_total));
    if (got.data.lowest_cell !== want.data.lowest_cell)
      report_mismatch($sformatf("%s lowest_cell got %0d want %0d", tag,
                                got.data.lowest_cell, want.data.lowest_cell));
  endtask

  // result side: every transfer is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.flag_update = out_tuser;
      got.frame_done  = out_tlast;
      got.data        = result_data_t'(out_tdata);
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        check_result(got, expected_results.pop_front());
      end
      results_seen++;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender and register writes
  // ---------------------------------------------------------------------------
  // offer one reading, wait for its transfer, then log the expected result
  task automatic send_reading(input logic [VOLT_W-1:0] volt, input logic failed,
                              input logic last, input bit has_known, input result_t known);
    result_t pred;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= volt;
    in_tuser  <= failed;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = predict_cell(volt, failed, last);
    expected_results.push_back(has_known ? known : pred);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_CELL_LOW:  lim_low  = val[VOLT_W-1:0];
      REG_CELL_HIGH: lim_high = val[VOLT_W-1:0];
      REG_PACK_LOW:  pack_min = val[TOTAL_W-1:0];
      REG_SKIPPED:   skip_cnt = val[SKIP_W-1:0];
      default: ;
    endcase
  endtask

  // drain, reprogram all limits, then stream random frames
  task automatic run_phase(input logic [VOLT_W-1:0] low, input logic [VOLT_W-1:0] high,
                           input logic [TOTAL_W-1:0] pack, input logic [SKIP_W-1:0] skip,
                           input int items, input bit squeeze);
    int sent;
    int len;
    int bad_pos;
    int kind;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    write_reg(REG_CELL_LOW, CFG_W'(low));
    write_reg(REG_CELL_HIGH, CFG_W'(high));
    write_reg(REG_PACK_LOW, CFG_W'(pack));
    write_reg(REG_SKIPPED, CFG_W'(skip));
    cfg_wr_en <= 1'b0;
    if (squeeze) long_hold = 1'b1;
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 8) begin
        // well-formed frame: mostly full length, sometimes short, rarely very long
        if (kind == 8) len = $urandom_range(15, 20);
        else if ($urandom_range(0, 3) == 0) len = $urandom_range(1, CELLS + 2);
        else len = CELLS;
        bad_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++)
          send_reading(pick_voltage(), i == bad_pos, i == len - 1, 1'b0, '0);
        sent += len;
      end else begin
        // noise: raw readings with random failure and frame-end marks
        for (int i = 0; i < 8; i++)
          send_reading(VOLT_W'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0,
                       $urandom_range(0, 3) == 0, 1'b0, '0);
        sent += 8;
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    logic [VOLT_W-1:0] lo;
    logic [VOLT_W-1:0] hi;
    int wait_cycles;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= REG_CELL_LOW;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, default limits: low 30000, high 42000, pack 180000, no skip
    // full frame: zero, all ones, healthy, both limits exactly, closes as overvoltage
    add_row(16'd0,     1'b0, 1'b0, 1'b1, cell_result(0, 1, 1, 0, 0, STATUS_OK, 0, 0));
    add_row(16'd65535, 1'b0, 1'b0, 1'b1, cell_result(1, 1, 0, 1, 0, STATUS_OK, 0, 0));
    add_row(16'd36000, 1'b0, 1'b0, 1'b1, cell_result(2, 1, 0, 0, 0, STATUS_OK, 0, 0));
    add_row(16'd30000, 1'b0, 1'b0, 1'b1, cell_result(3, 1, 1, 0, 0, STATUS_OK, 0, 0));
    add_row(16'd42000, 1'b0, 1'b0, 1'b1, cell_result(4, 1, 0, 1, 0, STATUS_OK, 0, 0));
    add_row(16'd30001, 1'b0, 1'b1, 1'b1,
            cell_result(5, 1, 0, 0, 1, STATUS_OVER, 203536, 0));
    // read failure mid-frame: no flag updates from there on, status read error
    add_row(16'd36000, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd36000, 1'b1, 1'b0, 1'b1, cell_result(1, 0, 0, 0, 0, STATUS_OK, 0, 0));
    add_row(16'd29000, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd36000, 1'b0, 1'b1, 1'b1,
            cell_result(3, 0, 0, 0, 1, STATUS_READ_ERR, 137000, 2));
    // single healthy cell: pack total below limit forces undervoltage
    add_row(16'd41999, 1'b0, 1'b1, 1'b1,
            cell_result(0, 1, 0, 0, 1, STATUS_UNDER, 41999, 0));
    // frame past CELLS: trailing low cells are inactive, tie keeps first index
    add_row(16'd40000, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd35000, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd35000, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd40000, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd40000, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd40000, 1'b0, 1'b0, 1'b0, '0);
    add_row(16'd10000, 1'b0, 1'b0, 1'b1, cell_result(6, 0, 0, 0, 0, STATUS_OK, 0, 0));
    add_row(16'd10000, 1'b0, 1'b1, 1'b1,
            cell_result(7, 0, 0, 0, 1, STATUS_OK, 230000, 1));
    // failure flagged on the only cell of a frame
    add_row(16'd65535, 1'b1, 1'b1, 1'b1,
            cell_result(0, 0, 0, 0, 1, STATUS_READ_ERR, 65535, 0));

    foreach (directed_rows[i])
      send_reading(directed_rows[i].volt, directed_rows[i].failed, directed_rows[i].last,
                   directed_rows[i].has_known, directed_rows[i].known);
    in_tvalid <= 1'b0;

    // default limits with two dead cells, long output hold-off to fill the pipe
    run_phase(CELL_LOW_RST, CELL_HIGH_RST, PACK_LOW_RST, 4'd2, 140, 1'b1);
    // widest window: only zero is under and only all ones is over, no pack limit
    run_phase(16'd0, 16'd65535, 20'd0, 4'd0, 90, 1'b0);
    // inverted limits, max pack limit, every cell skipped
    run_phase(16'd65535, 16'd0, TOTAL_MAX, 4'd15, 70, 1'b0);

    lo = VOLT_W'($urandom_range(20000, 38000));
    hi = VOLT_W'($urandom_range(lo, 65535));
    run_phase(lo, hi, TOTAL_W'($urandom_range(0, 300000)), SKIP_W'($urandom_range(0, 6)),
              150, 1'b0);

    // final stretch runs flat out on both sides
    quiet = 1'b1;
    lo = VOLT_W'($urandom_range(20000, 38000));
    hi = VOLT_W'($urandom_range(lo, 65535));
    run_phase(lo, hi, TOTAL_W'($urandom_range(0, 300000)), SKIP_W'($urandom_range(0, 6)),
              150, 1'b0);

    for (wait_cycles = 0; wait_cycles < 2000 && expected_results.size() != 0; wait_cycles++)
      @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));
    // wait on a little to catch any stray result
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
